// ===== rtl/dsfp_pkg.sv =====
// Shared types and constants of the dust sensor frame parser.
package dsfp_pkg;

  // Payload lengths of the two frame families
  localparam int unsigned QUERY_LEN = 15;
  localparam int unsigned REPLY_LEN = 6;

  // Result status
  localparam logic [1:0] STATUS_RUN   = 2'd0;
  localparam logic [1:0] STATUS_READY = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_BEGIN    = 3'd1;
  localparam logic [2:0] ERR_COMMAND  = 3'd2;
  localparam logic [2:0] ERR_CHECKSUM = 3'd3;
  localparam logic [2:0] ERR_END      = 3'd4;
  localparam logic [2:0] ERR_TYPE     = 3'd5;
  localparam logic [2:0] ERR_DATA     = 3'd6;

  // Message kinds as carried in payload byte 0
  localparam logic [7:0] KIND_REPORT = 8'd2;
  localparam logic [7:0] KIND_DATA   = 8'd4;
  localparam logic [7:0] KIND_ID     = 8'd5;
  localparam logic [7:0] KIND_SLEEP  = 8'd6;
  localparam logic [7:0] KIND_FW     = 8'd7;
  localparam logic [7:0] KIND_WORK   = 8'd8;

  // Configuration register indexes
  localparam logic [2:0] REG_BEGIN    = 3'd0;
  localparam logic [2:0] REG_END      = 3'd1;
  localparam logic [2:0] REG_QUERY    = 3'd2;
  localparam logic [2:0] REG_REPLY    = 3'd3;
  localparam logic [2:0] REG_SAMPLE   = 3'd4;
  localparam logic [2:0] REG_INTERVAL = 3'd5;

  typedef logic [QUERY_LEN-1:0][7:0] payload_t;

  // Decoded message fields
  typedef struct packed {
    logic [3:0]  kind;
    logic        op;
    logic        from_host;
    logic [15:0] device_id;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [7:0]  setting;
    logic        interval_mode;
    logic [23:0] firmware_date;
  } msg_t;

endpackage

// ===== rtl/dsfp_decode.sv =====
// Message decode of a completed frame: kind choice, field checks, field extraction.
module dsfp_decode import dsfp_pkg::*; (
  input  payload_t   payload_i,
  input  logic [7:0] command_i,
  input  logic [7:0] query_code_i,
  input  logic [7:0] sample_code_i,
  input  logic [7:0] interval_limit_i,
  output logic [2:0] err_o,
  output msg_t       msg_o
);

  logic       host;
  logic [7:0] kind;
  logic [7:0] opb;
  logic [7:0] val;

  assign host = (command_i == query_code_i);
  assign kind = (command_i == sample_code_i) ? KIND_DATA : payload_i[0];
  assign opb  = payload_i[1];
  assign val  = payload_i[2];

  always_comb begin
    err_o = ERR_OK;
    msg_o = '0;
    if (kind inside {KIND_REPORT, KIND_SLEEP}) begin
      if ((opb > 8'd1) || (val > 8'd1)) begin
        err_o = ERR_DATA;
      end else begin
        msg_o.op      = opb[0];
        msg_o.setting = val;
      end
    end else if (kind == KIND_WORK) begin
      if ((opb > 8'd1) || (val > interval_limit_i)) begin
        err_o = ERR_DATA;
      end else begin
        msg_o.op            = opb[0];
        msg_o.setting       = val;
        msg_o.interval_mode = (val != 8'd0);
      end
    end else if (kind == KIND_DATA) begin
      msg_o.op = 1'b0;
      if (!host) begin
        msg_o.first_word  = {payload_i[1], payload_i[0]};
        msg_o.second_word = {payload_i[3], payload_i[2]};
      end
    end else if (kind == KIND_ID) begin
      msg_o.op = 1'b1;
      if (host) begin
        msg_o.first_word = {payload_i[11], payload_i[12]};
      end
    end else if (kind == KIND_FW) begin
      msg_o.op = 1'b0;
      if (!host) begin
        msg_o.firmware_date = {payload_i[1], payload_i[2], payload_i[3]};
      end
    end else begin
      err_o = ERR_TYPE;
    end

    if (err_o == ERR_OK) begin
      msg_o.kind      = kind[3:0];
      msg_o.from_host = host;
      msg_o.device_id = host ? {payload_i[13], payload_i[14]}
                             : {payload_i[4], payload_i[5]};
    end else begin
      // drop all message fields on a failed decode
      msg_o = '0;
    end
  end

endmodule

// ===== rtl/dust_sensor_frame_parser.sv =====
// Top level of the dust sensor frame parser: byte stream in, one result per byte out.
//
// Usage:
//   Slave stream (s_axis_*) carries one received serial byte per item.
//   Master stream (m_axis_*) returns exactly one result item per input item:
//   tuser holds the status (running, message ready, error), tdata the last
//   error code and the decoded message fields, zero unless a message is ready.
//   The APB port holds the frame markers, command codes and interval limit;
//   write it only while the stream is idle. pready is always high.
// Timing: a result appears in the output register in the cycle after its byte
//   is accepted. Throughput: one byte per cycle when not stalled, set by the
//   single step of frame state update plus decode before the result register.
// Stall: the input side stays ready while the output register is empty or
//   being drained in the same cycle; when the receiver holds tready low with
//   a result waiting, the input side holds tready low and the frame state
//   holds until the result is taken.
// Reset: rst_ni clears the frame state to hunting for the begin marker,
//   restores the register defaults and empties the output register. The
//   payload store holds no reset value; every byte decoded is written within
//   the current frame.
module dust_sensor_frame_parser import dsfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] error_code, [6:3] msg_kind, [7] operation, [8] from_host,
  // [24:9] device_id, [40:25] first_word, [56:41] second_word,
  // [64:57] setting_byte, [65] interval_mode, [89:66] firmware_date, [95:90] zero
  output logic [95:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // frame phases
  localparam logic [2:0] PH_BEGIN = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_PAY   = 3'd2;
  localparam logic [2:0] PH_CHK   = 3'd3;
  localparam logic [2:0] PH_END   = 3'd4;

  // configuration registers
  logic [7:0] begin_q, end_q, query_q, reply_q, sample_q, limit_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q  <= 8'd170;
      end_q    <= 8'd171;
      query_q  <= 8'd180;
      reply_q  <= 8'd197;
      sample_q <= 8'd192;
      limit_q  <= 8'd30;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BEGIN:    begin_q  <= pwdata[7:0];
        REG_END:      end_q    <= pwdata[7:0];
        REG_QUERY:    query_q  <= pwdata[7:0];
        REG_REPLY:    reply_q  <= pwdata[7:0];
        REG_SAMPLE:   sample_q <= pwdata[7:0];
        REG_INTERVAL: limit_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BEGIN:    prdata = {24'd0, begin_q};
      REG_END:      prdata = {24'd0, end_q};
      REG_QUERY:    prdata = {24'd0, query_q};
      REG_REPLY:    prdata = {24'd0, reply_q};
      REG_SAMPLE:   prdata = {24'd0, sample_q};
      REG_INTERVAL: prdata = {24'd0, limit_q};
      default:      prdata = 32'd0;
    endcase
  end

  // handshake: take a byte whenever the result register frees up this cycle
  logic accept;
  logic out_valid_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // frame state
  logic [2:0] phase_q, phase_d;
  logic [7:0] cmd_q, cmd_d;
  logic [3:0] len_q, len_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] sum_q, sum_d;
  logic [2:0] err_q, err_d;
  payload_t   store_q;
  logic       store_we;

  logic [7:0] rx_byte;
  logic [1:0] status;
  msg_t       msg;
  logic [2:0] dec_err;
  msg_t       dec_msg;

  assign rx_byte = s_axis_tdata_i;

  dsfp_decode u_decode (
    .payload_i        (store_q),
    .command_i        (cmd_q),
    .query_code_i     (query_q),
    .sample_code_i    (sample_q),
    .interval_limit_i (limit_q),
    .err_o            (dec_err),
    .msg_o            (dec_msg)
  );

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    err_d    = err_q;
    status   = STATUS_RUN;
    msg      = '0;
    store_we = 1'b0;
    case (phase_q)
      PH_BEGIN: begin
        if (rx_byte != begin_q) begin
          cmd_d  = 8'd0;
          len_d  = 4'd0;
          idx_d  = 4'd0;
          sum_d  = 8'd0;
          err_d  = ERR_BEGIN;
          status = STATUS_ERROR;
        end else begin
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        if ((rx_byte == query_q) || (rx_byte == reply_q) || (rx_byte == sample_q)) begin
          // query length takes priority where codes overlap
          len_d   = (rx_byte == query_q) ? 4'(QUERY_LEN) : 4'(REPLY_LEN);
          cmd_d   = rx_byte;
          idx_d   = 4'd0;
          phase_d = PH_PAY;
        end else begin
          phase_d = PH_BEGIN;
          cmd_d   = 8'd0;
          len_d   = 4'd0;
          idx_d   = 4'd0;
          sum_d   = 8'd0;
          err_d   = ERR_COMMAND;
          status  = STATUS_ERROR;
        end
      end
      PH_PAY: begin
        store_we = (idx_q < 4'(QUERY_LEN));
        idx_d    = idx_q + 4'd1;
        sum_d    = sum_q + rx_byte;
        if (idx_d >= len_q) begin
          phase_d = PH_CHK;
        end
      end
      PH_CHK: begin
        if (rx_byte != sum_q) begin
          phase_d = PH_BEGIN;
          cmd_d   = 8'd0;
          len_d   = 4'd0;
          idx_d   = 4'd0;
          sum_d   = 8'd0;
          err_d   = ERR_CHECKSUM;
          status  = STATUS_ERROR;
        end else begin
          phase_d = PH_END;
        end
      end
      PH_END: begin
        phase_d = PH_BEGIN;
        cmd_d   = 8'd0;
        len_d   = 4'd0;
        idx_d   = 4'd0;
        sum_d   = 8'd0;
        if (rx_byte != end_q) begin
          err_d  = ERR_END;
          status = STATUS_ERROR;
        end else begin
          err_d = dec_err;
          if (dec_err != ERR_OK) begin
            status = STATUS_ERROR;
          end else begin
            status = STATUS_READY;
            msg    = dec_msg;
          end
        end
      end
      default: begin
        // unused phase: recover quietly
        phase_d = PH_BEGIN;
        cmd_d   = 8'd0;
        len_d   = 4'd0;
        idx_d   = 4'd0;
        sum_d   = 8'd0;
        err_d   = ERR_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BEGIN;
      cmd_q   <= 8'd0;
      len_q   <= 4'd0;
      idx_q   <= 4'd0;
      sum_q   <= 8'd0;
      err_q   <= ERR_OK;
    end else if (accept) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      err_q   <= err_d;
    end
  end

  // payload store: no reset, written only inside a frame
  always_ff @(posedge clk_i) begin
    if (accept && store_we) begin
      store_q[idx_q] <= rx_byte;
    end
  end

  // result register
  logic [95:0] tdata_q;
  logic [1:0]  tuser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tuser_q <= status;
      tdata_q <= {6'd0, msg.firmware_date, msg.interval_mode, msg.setting,
                  msg.second_word, msg.first_word, msg.device_id,
                  msg.from_host, msg.op, msg.kind, err_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

endmodule
